[hw/rtl/wstq_pkg.sv]
// Shared types, constants and codes for the work-stealing task queues.
package wstq_pkg;

  localparam int NUM_WORKERS = 8;
  localparam int QUEUE_DEPTH = 64;
  localparam int HANDLE_BITS = 32;

  localparam int WID_W  = $clog2(NUM_WORKERS);
  localparam int NW_W   = 4;
  localparam int SLOT_W = $clog2(QUEUE_DEPTH);
  localparam int CNT_W  = 7;
  localparam int ADDR_W = WID_W + SLOT_W;
  localparam int WAIT_W = 10;
  localparam int PADDR_W = 3;

  localparam logic [WAIT_W-1:0] WAIT_MAX      = '1;
  localparam logic [NW_W-1:0]   NW_RESET      = NW_W'(NUM_WORKERS);
  localparam logic [CNT_W-1:0]  CAP_RESET     = CNT_W'(QUEUE_DEPTH);

  typedef enum logic {
    REG_WORKERS  = 1'b0,
    REG_CAPACITY = 1'b1
  } reg_idx_t;

  typedef enum logic {
    CMD_PUSH = 1'b0,
    CMD_POP  = 1'b1
  } cmd_t;

  typedef enum logic [2:0] {
    ST_PUSHED     = 3'd0,
    ST_FULL       = 3'd1,
    ST_OWN_POP    = 3'd2,
    ST_STOLEN     = 3'd3,
    ST_NONE_FOUND = 3'd4,
    ST_BAD_WORKER = 3'd5
  } status_t;

  typedef enum logic {
    FSM_IDLE = 1'b0,
    FSM_EXEC = 1'b1
  } fsm_t;

  typedef struct packed {
    logic                   cmd;
    logic [2:0]             worker_id;
    logic [31:0]            task_in;
  } req_word_t;

  typedef struct packed {
    logic [2:0]             status;
    logic [31:0]            task_out;
    logic [2:0]             source_queue;
    logic [WAIT_W-1:0]      waiting_count;
  } rsp_word_t;

  typedef struct packed {
    logic [NW_W-1:0]        active_workers;
    logic [CNT_W-1:0]       active_capacity;
  } cfg_t;

  typedef struct packed {
    logic                   wr_en;
    logic                   rd_en;
    logic [ADDR_W-1:0]      addr;
    logic [HANDLE_BITS-1:0] wdata;
  } mem_req_t;

endpackage

[hw/rtl/wstq_cfg.sv]
// Configuration registers behind the APB-style port, with clamped active values.
module wstq_cfg (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [wstq_pkg::PADDR_W-1:0]  paddr,
  input  logic [31:0]                   pwdata,
  output logic [31:0]                   prdata,
  output logic                          pready,
  output wstq_pkg::cfg_t                cfg
);

  logic [wstq_pkg::NW_W-1:0]  worker_lim;
  logic [wstq_pkg::CNT_W-1:0] capacity_lim;
  logic                       wr_hit;
  wstq_pkg::reg_idx_t         idx;

  assign pready = 1'b1;
  assign idx    = wstq_pkg::reg_idx_t'(paddr[2]);
  assign wr_hit = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      worker_lim   <= wstq_pkg::NW_RESET;
      capacity_lim <= wstq_pkg::CAP_RESET;
    end else if (wr_hit) begin
      unique case (idx)
        wstq_pkg::REG_WORKERS:  worker_lim   <= pwdata[wstq_pkg::NW_W-1:0];
        wstq_pkg::REG_CAPACITY: capacity_lim <= pwdata[wstq_pkg::CNT_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      wstq_pkg::REG_WORKERS:
        prdata = {{(32-wstq_pkg::NW_W){1'b0}}, worker_lim};
      wstq_pkg::REG_CAPACITY:
        prdata = {{(32-wstq_pkg::CNT_W){1'b0}}, capacity_lim};
      default: prdata = '0;
    endcase
  end

  always_comb begin
    if (worker_lim == '0) begin
      cfg.active_workers = wstq_pkg::NW_W'(1);
    end else if (worker_lim > wstq_pkg::NW_W'(wstq_pkg::NUM_WORKERS)) begin
      cfg.active_workers = wstq_pkg::NW_W'(wstq_pkg::NUM_WORKERS);
    end else begin
      cfg.active_workers = worker_lim;
    end
    if (capacity_lim == '0) begin
      cfg.active_capacity = wstq_pkg::CNT_W'(1);
    end else if (capacity_lim > wstq_pkg::CNT_W'(wstq_pkg::QUEUE_DEPTH)) begin
      cfg.active_capacity = wstq_pkg::CNT_W'(wstq_pkg::QUEUE_DEPTH);
    end else begin
      cfg.active_capacity = capacity_lim;
    end
  end

endmodule

[hw/rtl/wstq_store.sv]
// Task handle memory: one synchronous port, registered read data.
module wstq_store (
  input  logic                                clk,
  input  wstq_pkg::mem_req_t                  mreq,
  output logic [wstq_pkg::HANDLE_BITS-1:0]    rdata
);

  logic [wstq_pkg::HANDLE_BITS-1:0] mem [wstq_pkg::NUM_WORKERS*wstq_pkg::QUEUE_DEPTH];

  always_ff @(posedge clk) begin
    if (mreq.wr_en) begin
      mem[mreq.addr] <= mreq.wdata;
    end
    if (mreq.rd_en) begin
      rdata <= mem[mreq.addr];
    end
  end

endmodule

[hw/rtl/wstq_ctrl.sv]
// Request sequencer: deque pointers, victim search, memory access and result register.
module wstq_ctrl (
  input  logic                                clk,
  input  logic                                rst,
  input  wstq_pkg::cfg_t                      cfg,
  input  logic                                req_valid,
  output logic                                req_ready,
  input  wstq_pkg::req_word_t                 req,
  output logic                                rsp_valid,
  input  logic                                rsp_ready,
  output wstq_pkg::rsp_word_t                 rsp,
  output wstq_pkg::mem_req_t                  mreq,
  input  logic [wstq_pkg::HANDLE_BITS-1:0]    rdata
);

  localparam int NW    = wstq_pkg::NUM_WORKERS;
  localparam int WID_W = wstq_pkg::WID_W;
  localparam int NW_W  = wstq_pkg::NW_W;
  localparam int CNT_W = wstq_pkg::CNT_W;
  localparam int SLT_W = wstq_pkg::SLOT_W;

  wstq_pkg::fsm_t              state, state_next;
  wstq_pkg::req_word_t         cur;
  logic [SLT_W-1:0]            deque_top [NW];
  logic [CNT_W-1:0]            deque_count [NW];
  logic [wstq_pkg::WAIT_W-1:0] waiting_total, waiting_total_next;
  logic [NW-1:0]               nonempty;

  logic [2:0]                  rsp_status;
  logic [2:0]                  rsp_src;
  logic                        rsp_has_task;

  logic                        take;
  logic                        exec_go;
  logic [WID_W-1:0]            wid;
  logic                        bad;
  logic                        own_nonempty;
  logic                        found;
  logic [WID_W-1:0]            victim;
  logic [WID_W-1:0]            q;
  logic [SLT_W-1:0]            q_top;
  logic [CNT_W-1:0]            q_count;
  logic [SLT_W-1:0]            slot;
  logic                        do_push;
  logic                        do_own;
  logic                        do_steal;
  logic [2:0]                  status_next;
  logic [2:0]                  src_next;

  always_comb begin
    for (int i = 0; i < NW; i++) begin
      nonempty[i] = (deque_count[i] != '0);
    end
  end

  assign take = req_valid && req_ready;
  assign wid  = cur.worker_id;
  assign bad  = ({1'b0, wid} >= cfg.active_workers);
  assign own_nonempty = nonempty[wid];

  always_comb begin
    logic [NW_W-1:0] cand;
    found  = 1'b0;
    victim = '0;
    cand   = '0;
    for (int k = 1; k < NW; k++) begin
      cand = {1'b0, wid} + NW_W'(k);
      if (cand >= cfg.active_workers) begin
        cand = cand - cfg.active_workers;
      end
      if (!found && (NW_W'(k) < cfg.active_workers) && nonempty[cand[WID_W-1:0]]) begin
        found  = 1'b1;
        victim = cand[WID_W-1:0];
      end
    end
  end

  assign q       = (cur.cmd == wstq_pkg::CMD_PUSH || own_nonempty) ? wid : victim;
  assign q_top   = deque_top[q];
  assign q_count = deque_count[q];

  always_comb begin
    do_push     = 1'b0;
    do_own      = 1'b0;
    do_steal    = 1'b0;
    status_next = wstq_pkg::ST_BAD_WORKER;
    src_next    = 3'(wid);
    slot        = q_top;
    if (bad) begin
      status_next = wstq_pkg::ST_BAD_WORKER;
      src_next    = '0;
    end else if (cur.cmd == wstq_pkg::CMD_PUSH) begin
      slot = q_top + q_count[SLT_W-1:0];
      if (q_count >= cfg.active_capacity) begin
        status_next = wstq_pkg::ST_FULL;
      end else begin
        do_push     = 1'b1;
        status_next = wstq_pkg::ST_PUSHED;
      end
    end else if (own_nonempty) begin
      slot        = q_top + SLT_W'(q_count - CNT_W'(1));
      do_own      = 1'b1;
      status_next = wstq_pkg::ST_OWN_POP;
    end else if (found) begin
      slot        = q_top;
      do_steal    = 1'b1;
      status_next = wstq_pkg::ST_STOLEN;
      src_next    = 3'(victim);
    end else begin
      status_next = wstq_pkg::ST_NONE_FOUND;
    end
  end

  always_comb begin
    waiting_total_next = waiting_total;
    if (do_push && waiting_total != wstq_pkg::WAIT_MAX) begin
      waiting_total_next = waiting_total + 1'b1;
    end else if ((do_own || do_steal) && waiting_total != '0) begin
      waiting_total_next = waiting_total - 1'b1;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      wstq_pkg::FSM_IDLE: if (take) state_next = wstq_pkg::FSM_EXEC;
      wstq_pkg::FSM_EXEC: if (!rsp_valid || rsp_ready) state_next = wstq_pkg::FSM_IDLE;
      default: state_next = wstq_pkg::FSM_IDLE;
    endcase
  end

  always_comb begin
    req_ready = 1'b0;
    exec_go   = 1'b0;
    unique case (state)
      wstq_pkg::FSM_IDLE: req_ready = 1'b1;
      wstq_pkg::FSM_EXEC: exec_go = !rsp_valid || rsp_ready;
      default: ;
    endcase
  end

  assign mreq.wr_en = exec_go && do_push;
  assign mreq.rd_en = exec_go && (do_own || do_steal);
  assign mreq.addr  = {q, slot};
  assign mreq.wdata = cur.task_in;

  always_ff @(posedge clk) begin
    if (take) begin
      cur <= req;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= wstq_pkg::FSM_IDLE;
      waiting_total <= '0;
      rsp_valid     <= 1'b0;
      for (int i = 0; i < NW; i++) begin
        deque_top[i]   <= '0;
        deque_count[i] <= '0;
      end
    end else begin
      state <= state_next;
      if (exec_go) begin
        waiting_total <= waiting_total_next;
        rsp_valid     <= 1'b1;
        if (do_push) begin
          deque_count[q] <= q_count + 1'b1;
        end else if (do_own) begin
          deque_count[q] <= q_count - 1'b1;
        end else if (do_steal) begin
          deque_count[q] <= q_count - 1'b1;
          deque_top[q]   <= q_top + 1'b1;
        end
      end else if (rsp_ready) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (exec_go) begin
      rsp_status    <= status_next;
      rsp_src       <= src_next;
      rsp_has_task  <= do_own || do_steal;
    end
  end

  assign rsp.status        = rsp_status;
  assign rsp.task_out      = rsp_has_task ? rdata : '0;
  assign rsp.source_queue  = rsp_src;
  assign rsp.waiting_count = waiting_total;

endmodule

[hw/rtl/work_stealing_task_queues.sv]
// Top level of the work-stealing task queues: per-worker deques of task handles.
// Each word is handled in order: the request is registered, then the empty flags
// are searched and the task memory is read or written; the result is registered after that.
// No new request is taken until the last one has accessed the task memory.
// Synchronous reset empties every deque and clears the waiting count; the task
// memory itself is not cleared, as only written slots are ever read back.
module work_stealing_task_queues (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          req_valid,
  output logic                          req_ready,
  input  wstq_pkg::req_word_t           req,
  output logic                          rsp_valid,
  input  logic                          rsp_ready,
  output wstq_pkg::rsp_word_t           rsp,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [wstq_pkg::PADDR_W-1:0]  paddr,
  input  logic [31:0]                   pwdata,
  output logic [31:0]                   prdata,
  output logic                          pready
);

  wstq_pkg::cfg_t                       cfg;
  wstq_pkg::mem_req_t                   mreq;
  logic [wstq_pkg::HANDLE_BITS-1:0]     rdata;

  wstq_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  wstq_store u_store (
    .clk   (clk),
    .mreq  (mreq),
    .rdata (rdata)
  );

  wstq_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp),
    .mreq      (mreq),
    .rdata     (rdata)
  );

endmodule
